### rtl/core/fpsa_pkg.sv
// Shared types, sizes and codes for the fit-policy segment allocator.
// Used by fpsa_cell, fpsa_ctrl and the top level; depends on nothing.
`default_nettype none

package fpsa_pkg;

  // Table shape
  localparam int MAX_SEGMENTS = 64;
  localparam int SIZE_BITS    = 16;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 1'd1;

  // Reset value of the pool size register
  localparam logic [CFG_DATA_W-1:0] POOL_RESET = 16'd800;

  // Fit policies
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Candidate that ripples along the cell row
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } tok_t;

  // Search context broadcast to every cell
  typedef struct packed {
    logic [1:0]           mode;
    logic [SIZE_BITS-1:0] req;
    logic [CNT_W-1:0]     count;
  } scan_t;

  // Table update broadcast to every cell
  typedef struct packed {
    logic                 init;
    logic                 alloc;
    logic                 split;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] req;
    logic [SIZE_BITS-1:0] left;
    logic [SIZE_BITS-1:0] pool;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/fpsa_cell.sv
// One table entry of the segment allocator: size, free mark and a candidate stage.
// Depends on fpsa_pkg.
`default_nettype none

module fpsa_cell (
  input  wire logic                         clk,
  input  wire logic [fpsa_pkg::IDX_W-1:0]     cell_idx,
  input  wire fpsa_pkg::scan_t                scan,
  input  wire fpsa_pkg::cmd_t                 cmd,
  input  wire fpsa_pkg::tok_t                 tok_in,
  input  wire logic [fpsa_pkg::SIZE_BITS-1:0] prev_size,
  input  wire logic                           prev_free,
  output fpsa_pkg::tok_t                      tok_out,
  output logic [fpsa_pkg::SIZE_BITS-1:0]      size_out,
  output logic                                free_out
);
  import fpsa_pkg::*;

  logic [SIZE_BITS-1:0] size_r;
  logic                 free_r;
  tok_t                 tok_r;
  tok_t                 tok_nxt;
  logic                 in_use;
  logic                 fits;
  logic                 take;
  logic [IDX_W:0]       idx_ext;
  logic [IDX_W:0]       after_pick;

  // Compare own entry against the incoming candidate
  always_comb begin
    in_use = {1'b0, cell_idx} < scan.count;
    fits   = in_use && free_r && (size_r >= scan.req);
    case (scan.mode)
      MODE_FIRST: take = fits && !tok_in.found;
      MODE_BEST:  take = fits && (!tok_in.found || size_r < tok_in.size);
      MODE_WORST: take = fits && (!tok_in.found || size_r > tok_in.size);
      default:    take = 1'b0;
    endcase
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = cell_idx;
      tok_nxt.size  = size_r;
    end else begin
      tok_nxt = tok_in;
    end
  end

  // Hand the candidate to the next cell
  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign idx_ext    = {1'b0, cell_idx};
  assign after_pick = {1'b0, cmd.pick} + {{IDX_W{1'b0}}, 1'b1};

  // Load, resize, or shift the entry down from its neighbor
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      if (cell_idx == '0) begin
        size_r <= cmd.pool;
        free_r <= 1'b1;
      end
    end else if (cmd.alloc) begin
      if (cell_idx == cmd.pick) begin
        size_r <= cmd.req;
        free_r <= 1'b0;
      end else if (cmd.split && idx_ext == after_pick) begin
        size_r <= cmd.left;
        free_r <= 1'b1;
      end else if (cmd.split && idx_ext > after_pick) begin
        size_r <= prev_size;
        free_r <= prev_free;
      end
    end
  end

  assign tok_out  = tok_r;
  assign size_out = size_r;
  assign free_out = free_r;

endmodule

`default_nettype wire

### rtl/core/fpsa_ctrl.sv
// Sequencer of the segment allocator: registers, scan timing, commit and result word.
// Depends on fpsa_pkg.
`default_nettype none

module fpsa_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [fpsa_pkg::SIZE_BITS-1:0]      in_request_size,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fpsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fpsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire fpsa_pkg::tok_t                      last_tok,
  output fpsa_pkg::scan_t                          scan,
  output fpsa_pkg::cmd_t                           cmd,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [fpsa_pkg::IDX_W-1:0]               out_segment_index,
  output logic [fpsa_pkg::CNT_W-1:0]               out_segment_total
);
  import fpsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_SEGMENTS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     step_r, step_nxt;
  logic [SIZE_BITS-1:0] req_r;
  logic [1:0]           mode_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 valid_r;
  logic [1:0]           status_r, status_nxt;
  logic [IDX_W-1:0]     index_r, index_nxt;
  logic [CNT_W-1:0]     total_r;
  logic                 accept;
  logic                 pool_wr;
  logic                 need_split;
  logic                 do_alloc;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign pool_wr   = cfg_valid && cfg_ready && (cfg_index == REG_POOL_SIZE);

  // Decide the outcome from the candidate that left the last cell
  always_comb begin
    need_split = last_tok.found && (last_tok.size > req_r);
    status_nxt = ST_OK;
    index_nxt  = '0;
    do_alloc   = 1'b0;
    count_nxt  = count_r;
    if (!last_tok.found) begin
      status_nxt = ST_NOFIT;
    end else if (need_split && count_r == CNT_FULL) begin
      status_nxt = ST_FULL;
    end else begin
      do_alloc  = 1'b1;
      index_nxt = last_tok.idx;
      if (need_split) begin
        count_nxt = count_r + CNT_ONE;
      end
    end
  end

  // Broadcast the search context and the table update
  always_comb begin
    scan.mode  = mode_r;
    scan.req   = req_r;
    scan.count = count_r;
    cmd.init   = !rst_n || pool_wr;
    cmd.alloc  = (state_r == S_COMMIT) && do_alloc;
    cmd.split  = need_split;
    cmd.pick   = last_tok.idx;
    cmd.req    = req_r;
    cmd.left   = last_tok.size - req_r;
    cmd.pool   = rst_n ? SIZE_BITS'(cfg_data) : SIZE_BITS'(POOL_RESET);
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          step_nxt  = '0;
        end
      end
      S_SCAN: begin
        step_nxt = step_r + IDX_W'(1);
        if (step_r == SCAN_LAST) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      mode_r  <= MODE_FIRST;
      count_r <= CNT_ONE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      valid_r <= (state_r == S_COMMIT);
      if (cfg_valid && cfg_ready && cfg_index == REG_ALLOC_MODE) begin
        mode_r <= cfg_data[1:0];
      end
      if (pool_wr) begin
        count_r <= CNT_ONE;
      end else if (state_r == S_COMMIT) begin
        count_r <= count_nxt;
      end
    end
  end

  // Hold the request and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_request_size;
    end
    if (state_r == S_COMMIT) begin
      status_r <= status_nxt;
      index_r  <= index_nxt;
      total_r  <= count_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_segment_index = index_r;
  assign out_segment_total = total_r;

endmodule

`default_nettype wire

### rtl/core/fit_policy_segment_allocator_top.sv
// Top level of the fit-policy segment allocator: a row of table cells and a sequencer.
// Depends on fpsa_pkg, fpsa_cell and fpsa_ctrl.
//
//   channel  handshake            word
//   in       start / busy         in_request_size
//   out      out_valid (strobe)   out_status, out_segment_index, out_segment_total
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request word is taken when start is high and busy is low. The candidate ripples
// one cell per cycle down the row of MAX_SEGMENTS cells during the scan state, then the
// commit state updates the table in parallel (split and shift). The result word is
// registered from the commit state; it strobes in the same cycle that busy drops.
// Synchronous reset loads one free segment of 800 units; a pool_size write does
// the same with the written size. The receiver takes each result as it appears.
`default_nettype none

module fit_policy_segment_allocator_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [fpsa_pkg::SIZE_BITS-1:0]      in_request_size,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [fpsa_pkg::IDX_W-1:0]               out_segment_index,
  output logic [fpsa_pkg::CNT_W-1:0]               out_segment_total,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fpsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fpsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fpsa_pkg::*;

  scan_t                scan;
  cmd_t                 cmd;
  tok_t                 tok_chain  [MAX_SEGMENTS+1];
  logic [SIZE_BITS-1:0] size_chain [MAX_SEGMENTS+1];
  logic                 free_chain [MAX_SEGMENTS+1];

  // Feed the head of the row with an empty candidate and an empty neighbor
  assign tok_chain[0]  = '0;
  assign size_chain[0] = '0;
  assign free_chain[0] = 1'b0;

  // Row of table cells
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    fpsa_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(i)),
      .scan      (scan),
      .cmd       (cmd),
      .tok_in    (tok_chain[i]),
      .prev_size (size_chain[i]),
      .prev_free (free_chain[i]),
      .tok_out   (tok_chain[i+1]),
      .size_out  (size_chain[i+1]),
      .free_out  (free_chain[i+1])
    );
  end

  // Sequencer and register file
  fpsa_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_request_size   (in_request_size),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .last_tok          (tok_chain[MAX_SEGMENTS]),
    .scan              (scan),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_segment_index (out_segment_index),
    .out_segment_total (out_segment_total)
  );

endmodule

`default_nettype wire

### tb/fit_policy_segment_allocator_top_test.sv
// Self-checking bench for fit_policy_segment_allocator_top: directed and random requests.
// A scoreboard class predicts each allocation word from its own copy of the segment table.
// Depends on fpsa_pkg and the allocator RTL.

module fit_policy_segment_allocator_top_test;
  import fpsa_pkg::*;

  typedef struct {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] total;
  } alloc_word_t;

  // Segment table predictor plus the queue of allocation words still to come
  class segment_alloc_sb;
    logic [1:0]           fit_mode;
    logic [SIZE_BITS-1:0] pool_len;
    logic [SIZE_BITS-1:0] seg_len [MAX_SEGMENTS];
    bit                   seg_open [MAX_SEGMENTS];
    int unsigned          n_seg;
    alloc_word_t          expected_allocs[$];
    int unsigned          errors;

    function new();
      fit_mode = MODE_FIRST;
      pool_len = POOL_RESET;
      errors   = 0;
      clear_table();
    endfunction

    function void clear_table();
      foreach (seg_len[i]) begin
        seg_len[i]  = '0;
        seg_open[i] = 1'b0;
      end
      seg_len[0]  = pool_len;
      seg_open[0] = 1'b1;
      n_seg       = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ALLOC_MODE) begin
        fit_mode = data[1:0];
      end else if (idx == REG_POOL_SIZE) begin
        pool_len = data[SIZE_BITS-1:0];
        clear_table();
      end
    endfunction

    // Size of the first free segment, or -1 when none is free
    function int free_len();
      for (int i = 0; i < n_seg; i++)
        if (seg_open[i]) return int'(seg_len[i]);
      return -1;
    endfunction

    function int unsigned outstanding();
      return expected_allocs.size();
    endfunction

    // Note an accepted request: pick a segment, split it and queue the word
    function void predict_alloc(logic [SIZE_BITS-1:0] req);
      alloc_word_t          w;
      bit                   hit;
      int                   pick;
      logic [SIZE_BITS-1:0] old;
      hit  = 1'b0;
      pick = 0;
      if (fit_mode == MODE_FIRST || fit_mode == MODE_BEST || fit_mode == MODE_WORST) begin
        for (int i = 0; i < n_seg; i++) begin
          if (seg_open[i] && seg_len[i] >= req) begin
            if (!hit ||
                (fit_mode == MODE_BEST && seg_len[i] < seg_len[pick]) ||
                (fit_mode == MODE_WORST && seg_len[i] > seg_len[pick])) begin
              pick = i;
              hit  = 1'b1;
            end
            if (fit_mode == MODE_FIRST) break;
          end
        end
      end
      w.index = '0;
      w.total = CNT_W'(n_seg);
      if (!hit) begin
        w.status = ST_NOFIT;
      end else begin
        old = seg_len[pick];
        if (old > req && n_seg >= MAX_SEGMENTS) begin
          w.status = ST_FULL;
        end else begin
          // Shift later entries down and insert the leftover after the pick
          if (old > req) begin
            for (int i = n_seg; i > pick + 1; i--) begin
              seg_len[i]  = seg_len[i-1];
              seg_open[i] = seg_open[i-1];
            end
            seg_len[pick+1]  = old - req;
            seg_open[pick+1] = 1'b1;
            n_seg++;
          end
          seg_len[pick]  = req;
          seg_open[pick] = 1'b0;
          w.status = ST_OK;
          w.index  = IDX_W'(pick);
          w.total  = CNT_W'(n_seg);
        end
      end
      expected_allocs.push_back(w);
    endfunction

    task report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    // Compare one result word against the oldest expectation
    task check_result(logic [1:0] st, logic [IDX_W-1:0] ix, logic [CNT_W-1:0] tot);
      alloc_word_t e;
      if (expected_allocs.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: status=%0d idx=%0d total=%0d",
                                  st, ix, tot));
        return;
      end
      e = expected_allocs.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
      if (ix !== e.index)
        report_mismatch($sformatf("segment_index %0d, expected %0d", ix, e.index));
      if (tot !== e.total)
        report_mismatch($sformatf("segment_total %0d, expected %0d", tot, e.total));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [SIZE_BITS-1:0]  in_request_size;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [IDX_W-1:0]      out_segment_index;
  logic [CNT_W-1:0]      out_segment_total;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  segment_alloc_sb sb;
  int unsigned     n_sent;

  fit_policy_segment_allocator_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_request_size   (in_request_size),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_segment_index (out_segment_index),
    .out_segment_total (out_segment_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Check every strobed result word
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_segment_index, out_segment_total);
  end

  // Mostly no gap, some short ones, a few long ones that can span a whole request
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Offer one request word and hold it until taken; start stays high with no gap
  task automatic send_request(input logic [SIZE_BITS-1:0] req, input int gap);
    start           <= 1'b1;
    in_request_size <= req;
    do @(posedge clk); while (busy);
    sb.predict_alloc(req);
    n_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start           <= 1'b0;
      in_request_size <= SIZE_BITS'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Drop start and wait until every expected word has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Reconfigure while idle; upper mode bits are noise the block must mask
  task automatic set_config(input logic [1:0] mode, input logic [CFG_DATA_W-1:0] pool,
                            input bit with_pool);
    drain();
    write_reg(REG_ALLOC_MODE, {14'($urandom), mode});
    if (with_pool) write_reg(REG_POOL_SIZE, pool);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [SIZE_BITS-1:0] pick_request();
    int r;
    int fl;
    int lim;
    r   = $urandom_range(0, 99);
    fl  = sb.free_len();
    lim = (sb.pool_len >> 7) + 1;
    if (r < 70) return SIZE_BITS'($urandom_range(0, lim));
    if (r < 80 && fl >= 0) return SIZE_BITS'(fl);
    if (r < 88) return SIZE_BITS'($urandom_range(0, 65535));
    if (r < 94) return '0;
    if (fl >= 0) return SIZE_BITS'($urandom_range(0, fl));
    return SIZE_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pool();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CFG_DATA_W'($urandom_range(4096, 65535));
    if (r == 7) return 16'hFFFF;
    if (r == 8) return CFG_DATA_W'($urandom_range(1, 255));
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int phase_len;
    logic [1:0] mode;
    sb              = new();
    n_sent          = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_request_size <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_ALLOC_MODE;
    cfg_data        <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset table: zero request, no fit, split, exact fit, nothing free left
    send_request(16'd0, 0);
    send_request(16'hFFFF, 0);
    send_request(16'd100, 1);
    send_request(16'd700, 0);
    send_request(16'd1, 2);

    // Zero pool: a zero request fits exactly once
    set_config(MODE_FIRST, 16'd0, 1'b1);
    send_request(16'd0, 0);
    send_request(16'd0, 0);
    send_request(16'd1, 0);

    // Unknown mode never allocates
    set_config(2'd3, 16'hFFFF, 1'b1);
    send_request(16'd0, 0);
    send_request(16'hFFFF, 0);

    // Best fit on a one-unit pool
    set_config(MODE_BEST, 16'd1, 1'b1);
    send_request(16'd1, 0);
    send_request(16'd0, 0);

    // Worst fit on the largest pool, then alternating bit patterns
    set_config(MODE_WORST, 16'hFFFF, 1'b1);
    send_request(16'hFFFF, 0);
    set_config(MODE_WORST, 16'hFFFF, 1'b1);
    send_request(16'h8000, 0);
    send_request(16'h5555, 3);
    send_request(16'h2AAA, 0);

    // Random phases: mostly small requests so the table fills up to its limit
    while (n_sent < 600) begin
      mode = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      set_config(mode, pick_pool(), $urandom_range(0, 4) != 0);
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        send_request(pick_request(), pick_gap());
        if ($urandom_range(0, 24) == 0) drain();
      end
    end

    drain();
    repeat (70) @(posedge clk);
    if (sb.errors == 0)
      $display("fit_policy_segment_allocator_top: match");
    else
      $display("fit_policy_segment_allocator_top: mismatch");
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #20000000;
    $display("fit_policy_segment_allocator_top: mismatch");
    $finish;
  end

endmodule
